@@ hw/rtl/c8_pkg.sv @@
// Shared constants, codes, request structs and the font table of the CHIP-8 core.
`default_nettype none
package c8_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int MEM_AW = 12;
  localparam int STACK_DEPTH = 16;
  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam int FB_ROWS = 32;
  localparam int FB_RW = 5;
  localparam int FB_COLS = 64;
  localparam int FB_CW = 6;
  localparam int FONT_BYTES = 80;
  localparam logic [MEM_AW-1:0] FONT_BASE = 12'd80;
  localparam logic [MEM_AW-1:0] PROGRAM_START = 12'h200;

  localparam int IN_W = 40;
  localparam int OUT_W = 88;

  // item kinds carried in in_tuser
  localparam logic [2:0] ITEM_EXEC = 3'd0;
  localparam logic [2:0] ITEM_TICK = 3'd1;
  localparam logic [2:0] ITEM_KEY  = 3'd2;
  localparam logic [2:0] ITEM_LOAD = 3'd3;
  localparam logic [2:0] ITEM_ROW  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_SHIFT_IN_PLACE = 2'd0;
  localparam logic [1:0] CFG_JUMP_ADDS_VX   = 2'd1;
  localparam logic [1:0] CFG_KEEP_INDEX     = 2'd2;

  // top opcode nibble
  localparam logic [3:0] OPC_SYS  = 4'h0;
  localparam logic [3:0] OPC_JP   = 4'h1;
  localparam logic [3:0] OPC_CALL = 4'h2;
  localparam logic [3:0] OPC_SEB  = 4'h3;
  localparam logic [3:0] OPC_SNEB = 4'h4;
  localparam logic [3:0] OPC_SER  = 4'h5;
  localparam logic [3:0] OPC_LDB  = 4'h6;
  localparam logic [3:0] OPC_ADDB = 4'h7;
  localparam logic [3:0] OPC_ALU  = 4'h8;
  localparam logic [3:0] OPC_SNER = 4'h9;
  localparam logic [3:0] OPC_LDI  = 4'hA;
  localparam logic [3:0] OPC_JPV  = 4'hB;
  localparam logic [3:0] OPC_RND  = 4'hC;
  localparam logic [3:0] OPC_DRW  = 4'hD;
  localparam logic [3:0] OPC_KEY  = 4'hE;
  localparam logic [3:0] OPC_MISC = 4'hF;

  localparam logic [11:0] NNN_CLS = 12'h0E0;
  localparam logic [11:0] NNN_RET = 12'h0EE;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] FX_GET_DT = 8'h07;
  localparam logic [7:0] FX_WAIT   = 8'h0A;
  localparam logic [7:0] FX_SET_DT = 8'h15;
  localparam logic [7:0] FX_SET_ST = 8'h18;
  localparam logic [7:0] FX_ADD_I  = 8'h1E;
  localparam logic [7:0] FX_FONT   = 8'h29;
  localparam logic [7:0] FX_BCD    = 8'h33;
  localparam logic [7:0] FX_STORE  = 8'h55;
  localparam logic [7:0] FX_LOAD   = 8'h65;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic       re;
    logic       we;
    logic [3:0] addr;
    logic [7:0] wdata;
  } reg_req_t;

  typedef struct packed {
    logic               re;
    logic               we;
    logic               clr;
    logic [FB_RW-1:0]   addr;
    logic [FB_COLS-1:0] wdata;
  } fb_req_t;

  localparam logic [7:0] GLYPHS [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // reset content of one memory byte: font glyphs at the font base, zero elsewhere
  function automatic logic [7:0] font_init(input logic [MEM_AW-1:0] a);
    logic [MEM_AW-1:0] off;
    off = a - FONT_BASE;
    if (a >= FONT_BASE && off < MEM_AW'(FONT_BYTES)) return GLYPHS[off[6:0]];
    return 8'h00;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/c8_mem.sv @@
// Main 4 KiB byte memory with the font/zero sweep after reset.
`default_nettype none
module c8_mem (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire c8_pkg::mem_req_t         req,
  output logic [7:0]                    rdata,
  output logic                          ready
);

  logic [7:0] mem [c8_pkg::MEM_BYTES];
  logic                      init_r;
  logic [c8_pkg::MEM_AW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= 1'b1;
      cnt_r  <= '0;
    end else if (init_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (&cnt_r) init_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (init_r) begin
      mem[cnt_r] <= c8_pkg::font_init(cnt_r);
    end else if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) rdata <= mem[req.addr];
  end

  assign ready = !init_r;

endmodule
`default_nettype wire

@@ hw/rtl/c8_regs.sv @@
// Register file V0..VF: one port with read and write enables on a shared address, unwritten entries read zero.
`default_nettype none
module c8_regs (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire c8_pkg::reg_req_t req,
  output logic [7:0]            rdata
);

  logic [7:0]  mem [16];
  logic [15:0] valid_r;
  logic [7:0]  q_r;
  logic        qv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) mem[req.addr] <= req.wdata;
    if (req.re) begin
      q_r  <= mem[req.addr];
      qv_r <= valid_r[req.addr];
    end
  end

  assign rdata = qv_r ? q_r : 8'h00;

endmodule
`default_nettype wire

@@ hw/rtl/c8_fb.sv @@
// Framebuffer rows; a row bit marks written rows so a clear only drops the row bits.
`default_nettype none
module c8_fb (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire c8_pkg::fb_req_t             req,
  output logic [c8_pkg::FB_COLS-1:0]       rdata
);

  logic [c8_pkg::FB_COLS-1:0] mem [c8_pkg::FB_ROWS];
  logic [c8_pkg::FB_ROWS-1:0] valid_r;
  logic [c8_pkg::FB_COLS-1:0] q_r;
  logic                       qv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.clr) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) mem[req.addr] <= req.wdata;
    if (req.re) begin
      q_r  <= mem[req.addr];
      qv_r <= valid_r[req.addr];
    end
  end

  assign rdata = qv_r ? q_r : '0;

endmodule
`default_nettype wire

@@ hw/rtl/chip8_cpu_core.sv @@
// CHIP-8 core: item sequencer over main memory, register file and framebuffer.
//
// Channels: in_* carries one item (kind in in_tuser), out_* returns exactly one
// result per item, cfg_* writes the three quirk bits (always ready).
// After reset the main memory is swept (font at the font base, zero
// elsewhere); in_tready stays low during the sweep, config writes are taken.
// Path from accept to the final state:
//   tick, key event, load byte, unused kinds, execute while waiting: direct;
//   read display row: through the row state; execute: fetch, register reads,
//   execute, flag write if due, with a read and write per row for a draw,
//   a write per digit for BCD and a read and write per register for store/load.
// All work runs through the single-port memories, one access per cycle, so one
// item is in flight at a time; the next item is accepted as soon as the
// sequencer is back in idle, even while the previous result waits in the
// output register. A stalled receiver holds the result register and the
// sequencer waits in its final state until the register frees up.
`default_nettype none
module chip8_cpu_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // key_code[3:0], key_down[4], random_byte[12:5], load_address[24:13],
  // load_data[32:25], row_index[37:33], zero fill
  input  wire logic [c8_pkg::IN_W-1:0]   in_tdata,
  // operation[2:0]
  input  wire logic [2:0]                in_tuser,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // program_counter[11:0], flag_register[19:12], sound_on[20],
  // awaiting_key[21], display_changed[22], row_pixels[86:23], zero fill
  output logic [c8_pkg::OUT_W-1:0]       out_tdata,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [1:0]                cfg_index,
  input  wire logic                      cfg_data
);

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_FETCH0  = 17'h00002,
    S_FETCH1  = 17'h00004,
    S_FETCH2  = 17'h00008,
    S_RDX     = 17'h00010,
    S_RDY     = 17'h00020,
    S_EXEC    = 17'h00040,
    S_WRF     = 17'h00080,
    S_DRAW_RD = 17'h00100,
    S_DRAW_WR = 17'h00200,
    S_BCD     = 17'h00400,
    S_ST_RD   = 17'h00800,
    S_ST_WR   = 17'h01000,
    S_LD_RD   = 17'h02000,
    S_LD_WR   = 17'h04000,
    S_ROW     = 17'h08000,
    S_DONE    = 17'h10000
  } state_t;

  state_t state_r;

  c8_pkg::mem_req_t mreq;
  c8_pkg::reg_req_t rreq;
  c8_pkg::fb_req_t  freq;
  logic [7:0]                  mrdata;
  logic [7:0]                  vrdata;
  logic [c8_pkg::FB_COLS-1:0]  frdata;
  logic                        mem_ready;

  c8_mem u_mem (.clk(clk), .rst_n(rst_n), .req(mreq), .rdata(mrdata), .ready(mem_ready));
  c8_regs u_regs (.clk(clk), .rst_n(rst_n), .req(rreq), .rdata(vrdata));
  c8_fb u_fb (.clk(clk), .rst_n(rst_n), .req(freq), .rdata(frdata));

  // architectural state
  logic [11:0] pc_r;
  logic [15:0] idx_r;
  logic [c8_pkg::SP_W-1:0] sp_r;
  logic [11:0] stack_r [c8_pkg::STACK_DEPTH];
  logic [7:0]  dt_r, st_r;
  logic [15:0] keys_r;
  logic        wait_r;
  logic [3:0]  wtgt_r;
  logic [7:0]  vf_r;
  logic        shift_in_place_r, jump_adds_vx_r, keep_index_r;

  // per-item working registers
  logic [7:0]  hi_r, lo_r, vx_r, vy_r, rnd_r, flag_r;
  logic [3:0]  cnt_r;
  logic        hit_r, changed_r;
  logic [3:0]  bcd_r [3];
  logic [c8_pkg::FB_COLS-1:0] pix_r;
  logic        out_valid_r;
  logic [c8_pkg::OUT_W-1:0] out_data_r;

  logic        in_acc;
  logic [2:0]  item_op;
  logic [3:0]  in_key;
  logic        in_down;
  logic [7:0]  in_rnd;
  logic [11:0] in_addr;
  logic [7:0]  in_ldata;
  logic [4:0]  in_row;

  assign in_tready = (state_r == S_IDLE) && mem_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign item_op   = in_tuser;
  assign in_key    = in_tdata[3:0];
  assign in_down   = in_tdata[4];
  assign in_rnd    = in_tdata[12:5];
  assign in_addr   = in_tdata[24:13];
  assign in_ldata  = in_tdata[32:25];
  assign in_row    = in_tdata[37:33];

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // instruction fields
  logic [3:0]  opc, fx, fy, fn;
  logic [11:0] nnn, pc2, pc4, mem_off;
  logic [c8_pkg::SP_W-1:0] sp_dec, sp_inc;
  logic [4:0]  fb_row;
  assign opc = hi_r[7:4];
  assign fx  = hi_r[3:0];
  assign fy  = lo_r[7:4];
  assign fn  = lo_r[3:0];
  assign nnn = {hi_r[3:0], lo_r};
  assign pc2 = pc_r + 12'd2;
  assign pc4 = pc_r + 12'd4;
  assign mem_off = idx_r[11:0] + {8'h00, cnt_r};
  assign fb_row  = vy_r[4:0] + {1'b0, cnt_r};
  assign sp_dec = (sp_r == '0) ? c8_pkg::SP_W'(c8_pkg::STACK_DEPTH - 1) : sp_r - 1'b1;
  assign sp_inc = (sp_r == c8_pkg::SP_W'(c8_pkg::STACK_DEPTH - 1)) ? '0 : sp_r + 1'b1;

  // V[x] result of the executing instruction and the VF write that follows it
  logic       ex_wr, ex_fwr;
  logic [7:0] ex_res, ex_flag, sh_src;
  logic [8:0] sum9;
  always_comb begin
    ex_wr   = 1'b0;
    ex_fwr  = 1'b0;
    ex_res  = 8'h00;
    ex_flag = 8'h00;
    sh_src  = shift_in_place_r ? vx_r : vy_r;
    sum9    = {1'b0, vx_r} + {1'b0, vy_r};
    unique case (opc)
      c8_pkg::OPC_LDB:  begin ex_wr = 1'b1; ex_res = lo_r; end
      c8_pkg::OPC_ADDB: begin ex_wr = 1'b1; ex_res = vx_r + lo_r; end
      c8_pkg::OPC_RND:  begin ex_wr = 1'b1; ex_res = rnd_r & lo_r; end
      c8_pkg::OPC_MISC: begin
        if (lo_r == c8_pkg::FX_GET_DT) begin
          ex_wr  = 1'b1;
          ex_res = dt_r;
        end
      end
      c8_pkg::OPC_ALU: begin
        unique case (fn)
          c8_pkg::ALU_MOV: begin ex_wr = 1'b1; ex_res = vy_r; end
          c8_pkg::ALU_OR:  begin ex_wr = 1'b1; ex_res = vx_r | vy_r; end
          c8_pkg::ALU_AND: begin ex_wr = 1'b1; ex_res = vx_r & vy_r; end
          c8_pkg::ALU_XOR: begin ex_wr = 1'b1; ex_res = vx_r ^ vy_r; end
          c8_pkg::ALU_ADD: begin
            ex_wr = 1'b1; ex_fwr = 1'b1;
            ex_res = sum9[7:0]; ex_flag = {7'd0, sum9[8]};
          end
          c8_pkg::ALU_SUB: begin
            ex_wr = 1'b1; ex_fwr = 1'b1;
            ex_res = vx_r - vy_r; ex_flag = {7'd0, vx_r >= vy_r};
          end
          c8_pkg::ALU_SUBN: begin
            ex_wr = 1'b1; ex_fwr = 1'b1;
            ex_res = vy_r - vx_r; ex_flag = {7'd0, vy_r >= vx_r};
          end
          c8_pkg::ALU_SHR: begin
            ex_wr = 1'b1; ex_fwr = 1'b1;
            ex_res = {1'b0, sh_src[7:1]}; ex_flag = {7'd0, sh_src[0]};
          end
          c8_pkg::ALU_SHL: begin
            ex_wr = 1'b1; ex_fwr = 1'b1;
            ex_res = {sh_src[6:0], 1'b0}; ex_flag = {7'd0, sh_src[7]};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // program counter and follow-up state of the executing instruction
  logic [11:0] exec_pc;
  state_t      exec_state;
  always_comb begin
    exec_pc    = pc2;
    exec_state = ex_fwr ? S_WRF : S_DONE;
    unique case (opc)
      c8_pkg::OPC_SYS:  if (nnn == c8_pkg::NNN_RET) exec_pc = stack_r[sp_dec];
      c8_pkg::OPC_JP:   exec_pc = nnn;
      c8_pkg::OPC_CALL: exec_pc = nnn;
      c8_pkg::OPC_SEB:  if (vx_r == lo_r) exec_pc = pc4;
      c8_pkg::OPC_SNEB: if (vx_r != lo_r) exec_pc = pc4;
      c8_pkg::OPC_SER:  if (vx_r == vy_r) exec_pc = pc4;
      c8_pkg::OPC_SNER: if (vx_r != vy_r) exec_pc = pc4;
      c8_pkg::OPC_JPV:  exec_pc = nnn + {4'h0, jump_adds_vx_r ? vx_r : vrdata};
      c8_pkg::OPC_DRW:  exec_state = (fn == 4'd0) ? S_WRF : S_DRAW_RD;
      c8_pkg::OPC_KEY: begin
        if (lo_r == c8_pkg::KEY_SKP && keys_r[vx_r[3:0]]) exec_pc = pc4;
        if (lo_r == c8_pkg::KEY_SKNP && !keys_r[vx_r[3:0]]) exec_pc = pc4;
      end
      c8_pkg::OPC_MISC: begin
        unique case (lo_r)
          c8_pkg::FX_WAIT:  exec_pc = pc_r;
          c8_pkg::FX_BCD:   exec_state = S_BCD;
          c8_pkg::FX_STORE: exec_state = S_ST_RD;
          c8_pkg::FX_LOAD:  exec_state = S_LD_RD;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // BCD digits of Vx: hundreds by compare, tens by reciprocal multiply
  logic [1:0]  bcd_h;
  logic [6:0]  bcd_rem;
  logic [14:0] bcd_prod;
  logic [3:0]  bcd_t;
  logic [6:0]  bcd_o;
  always_comb begin
    if (vx_r >= 8'd200) begin
      bcd_h = 2'd2; bcd_rem = 7'(vx_r - 8'd200);
    end else if (vx_r >= 8'd100) begin
      bcd_h = 2'd1; bcd_rem = 7'(vx_r - 8'd100);
    end else begin
      bcd_h = 2'd0; bcd_rem = vx_r[6:0];
    end
    bcd_prod = 15'(bcd_rem) * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = bcd_rem - 7'(bcd_t) * 7'd10;
  end

  // sprite row mask: byte at column 0, rotated right by Vx
  logic [2*c8_pkg::FB_COLS-1:0] rot;
  logic [c8_pkg::FB_COLS-1:0]   spr_mask;
  always_comb begin
    rot = {mrdata, 56'd0, mrdata, 56'd0} >> vx_r[c8_pkg::FB_CW-1:0];
    spr_mask = rot[c8_pkg::FB_COLS-1:0];
  end

  // memory requests
  always_comb begin
    mreq = '0;
    rreq = '0;
    freq = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && item_op == c8_pkg::ITEM_LOAD) begin
          mreq.we = 1'b1; mreq.addr = in_addr; mreq.wdata = in_ldata;
        end
        if (in_acc && item_op == c8_pkg::ITEM_KEY && in_down && wait_r) begin
          rreq.we = 1'b1; rreq.addr = wtgt_r; rreq.wdata = {4'd0, in_key};
        end
        if (in_acc && item_op == c8_pkg::ITEM_ROW) begin
          freq.re = 1'b1; freq.addr = in_row;
        end
      end
      S_FETCH0: begin mreq.re = 1'b1; mreq.addr = pc_r; end
      S_FETCH1: begin mreq.re = 1'b1; mreq.addr = pc_r + 12'd1; end
      S_FETCH2: begin rreq.re = 1'b1; rreq.addr = hi_r[3:0]; end
      S_RDX:    begin rreq.re = 1'b1; rreq.addr = lo_r[7:4]; end
      S_RDY:    begin rreq.re = 1'b1; rreq.addr = 4'd0; end
      S_EXEC: begin
        rreq.we = ex_wr; rreq.addr = fx; rreq.wdata = ex_res;
        freq.clr = (opc == c8_pkg::OPC_SYS) && (nnn == c8_pkg::NNN_CLS);
      end
      S_WRF: begin rreq.we = 1'b1; rreq.addr = 4'hF; rreq.wdata = flag_r; end
      S_DRAW_RD: begin
        mreq.re = 1'b1; mreq.addr = mem_off;
        freq.re = 1'b1; freq.addr = fb_row;
      end
      S_DRAW_WR: begin
        freq.we = 1'b1; freq.addr = fb_row; freq.wdata = frdata ^ spr_mask;
      end
      S_BCD: begin
        mreq.we = 1'b1; mreq.addr = mem_off; mreq.wdata = {4'd0, bcd_r[cnt_r[1:0]]};
      end
      S_ST_RD: begin rreq.re = 1'b1; rreq.addr = cnt_r; end
      S_ST_WR: begin mreq.we = 1'b1; mreq.addr = mem_off; mreq.wdata = vrdata; end
      S_LD_RD: begin mreq.re = 1'b1; mreq.addr = mem_off; end
      S_LD_WR: begin rreq.we = 1'b1; rreq.addr = cnt_r; rreq.wdata = mrdata; end
      S_ROW, S_DONE: ;
      default: ;
    endcase
  end

  // shadow of VF for the result item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 8'h00;
    end else if (rreq.we && rreq.addr == 4'hF) begin
      vf_r <= rreq.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_in_place_r <= 1'b0;
      jump_adds_vx_r   <= 1'b0;
      keep_index_r     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        c8_pkg::CFG_SHIFT_IN_PLACE: shift_in_place_r <= cfg_data;
        c8_pkg::CFG_JUMP_ADDS_VX:   jump_adds_vx_r   <= cfg_data;
        c8_pkg::CFG_KEEP_INDEX:     keep_index_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= c8_pkg::PROGRAM_START;
      idx_r       <= 16'h0000;
      sp_r        <= '0;
      for (int i = 0; i < c8_pkg::STACK_DEPTH; i++) stack_r[i] <= 12'h000;
      dt_r        <= 8'h00;
      st_r        <= 8'h00;
      keys_r      <= 16'h0000;
      wait_r      <= 1'b0;
      wtgt_r      <= 4'h0;
      out_valid_r <= 1'b0;
      changed_r   <= 1'b0;
    end else begin
      // the final state drives the result register itself
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            changed_r <= 1'b0;
            pix_r     <= '0;
            rnd_r     <= in_rnd;
            case (item_op)
              c8_pkg::ITEM_EXEC: state_r <= wait_r ? S_DONE : S_FETCH0;
              c8_pkg::ITEM_TICK: begin
                if (dt_r != 8'h00) dt_r <= dt_r - 8'd1;
                if (st_r != 8'h00) st_r <= st_r - 8'd1;
                state_r <= S_DONE;
              end
              c8_pkg::ITEM_KEY: begin
                keys_r[in_key] <= in_down;
                if (in_down && wait_r) begin
                  wait_r <= 1'b0;
                  pc_r   <= pc2;
                end
                state_r <= S_DONE;
              end
              c8_pkg::ITEM_ROW: state_r <= S_ROW;
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_FETCH0: state_r <= S_FETCH1;
        S_FETCH1: begin hi_r <= mrdata; state_r <= S_FETCH2; end
        S_FETCH2: begin lo_r <= mrdata; state_r <= S_RDX; end
        S_RDX:    begin vx_r <= vrdata; state_r <= S_RDY; end
        S_RDY:    begin vy_r <= vrdata; state_r <= S_EXEC; end
        S_EXEC: begin
          pc_r    <= exec_pc;
          state_r <= exec_state;
          cnt_r   <= 4'd0;
          flag_r  <= ex_flag;
          unique case (opc)
            c8_pkg::OPC_SYS: begin
              if (nnn == c8_pkg::NNN_CLS) begin
                changed_r <= 1'b1;
              end else if (nnn == c8_pkg::NNN_RET) begin
                sp_r            <= sp_dec;
                stack_r[sp_dec] <= 12'h000;
              end
            end
            c8_pkg::OPC_CALL: begin
              stack_r[sp_r] <= pc2;
              sp_r          <= sp_inc;
            end
            c8_pkg::OPC_LDI: idx_r <= {4'h0, nnn};
            c8_pkg::OPC_DRW: begin
              changed_r <= 1'b1;
              hit_r     <= 1'b0;
            end
            c8_pkg::OPC_MISC: begin
              unique case (lo_r)
                c8_pkg::FX_WAIT: begin
                  wait_r <= 1'b1;
                  wtgt_r <= fx;
                end
                c8_pkg::FX_SET_DT: dt_r <= vx_r;
                c8_pkg::FX_SET_ST: st_r <= vx_r;
                c8_pkg::FX_ADD_I:  idx_r <= idx_r + {8'h00, vx_r};
                c8_pkg::FX_FONT:
                  idx_r <= {4'h0, c8_pkg::FONT_BASE} + {6'd0, vx_r, 2'b00} + {8'h00, vx_r};
                c8_pkg::FX_BCD: begin
                  bcd_r[0] <= {2'b00, bcd_h};
                  bcd_r[1] <= bcd_t;
                  bcd_r[2] <= bcd_o[3:0];
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        S_WRF: state_r <= S_DONE;
        S_DRAW_RD: state_r <= S_DRAW_WR;
        S_DRAW_WR: begin
          if (cnt_r == fn - 4'd1) begin
            flag_r  <= {7'd0, hit_r | (|(frdata & spr_mask))};
            state_r <= S_WRF;
          end else begin
            hit_r   <= hit_r | (|(frdata & spr_mask));
            cnt_r   <= cnt_r + 4'd1;
            state_r <= S_DRAW_RD;
          end
        end
        S_BCD: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd2) state_r <= S_DONE;
        end
        S_ST_RD: state_r <= S_ST_WR;
        S_LD_RD: state_r <= S_LD_WR;
        S_ST_WR, S_LD_WR: begin
          if (cnt_r == fx) begin
            if (!keep_index_r) idx_r <= idx_r + {12'h000, fx} + 16'd1;
            state_r <= S_DONE;
          end else begin
            cnt_r   <= cnt_r + 4'd1;
            state_r <= (state_r == S_ST_WR) ? S_ST_RD : S_LD_RD;
          end
        end
        S_ROW: begin pix_r <= frdata; state_r <= S_DONE; end
        S_DONE: begin
          // hold until the result register is free
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {1'b0, pix_r, changed_r, wait_r, st_r != 8'h00, vf_r, pc_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_wait_exec_noop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && item_op == c8_pkg::ITEM_EXEC && wait_r) |=> state_r == S_DONE)
    else $error("execute while waiting for a key did not finish at once");

  a_sweep_blocks_items: assert property (@(posedge clk) disable iff (!rst_n)
    !mem_ready |-> !in_tready)
    else $error("item accepted during memory sweep");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the final state");

  a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("item accepted while another is in flight");

endmodule
`default_nettype wire

@@ test/tb_chip8_cpu_core.sv @@
// Self-checking testbench of the CHIP-8 core: directed table, random programs, idling phases.
`timescale 1ns / 100ps
module tb_chip8_cpu_core;

  localparam int WATCHDOG_LIMIT = 12000;
  localparam int DRAIN_CYCLES   = 60;
  localparam logic [4:0] NO_WAIT = 5'd16;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  key;
    logic        down;
    logic [7:0]  rnd;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [4:0]  row;
    logic        typed;
  } item_t;

  // laid out as on out_tdata, highest field first
  typedef struct packed {
    logic [63:0] pixels;
    logic        changed;
    logic        waiting;
    logic        snd;
    logic [7:0]  vf;
    logic [11:0] pc;
  } status_t;

  localparam logic [2:0] ITEM_UNUSED = 3'd7;
  localparam int N_DIRECTED = 25;
  localparam item_t DIRECTED [N_DIRECTED] = '{
    '{c8_pkg::ITEM_ROW,  4'h0, 1'b0, 8'h00, 12'h000, 8'h00, 5'd31, 1'b1},
    '{c8_pkg::ITEM_LOAD, 4'h0, 1'b0, 8'h00, 12'h200, 8'h60, 5'd0,  1'b0},
    '{c8_pkg::ITEM_LOAD, 4'h0, 1'b0, 8'h00, 12'h201, 8'hFF, 5'd0,  1'b0},
    '{c8_pkg::ITEM_EXEC, 4'h0, 1'b0, 8'hFF, 12'h000, 8'h00, 5'd0,  1'b0},
    '{c8_pkg::ITEM_LOAD, 4'h0, 1'b0, 8'h00, 12'h202, 8'h80, 5'd0,  1'b0},
    '{c8_pkg::ITEM_LOAD, 4'h0, 1'b0, 8'h00, 12'h203, 8'h04, 5'd0,  1'b0},
    '{c8_pkg::ITEM_EXEC, 4'h0, 1'b0, 8'h00, 12'h000, 8'h00, 5'd0,  1'b0},
    '{c8_pkg::ITEM_LOAD, 4'h0, 1'b0, 8'h00, 12'h000, 8'hFF, 5'd0,  1'b0},
    '{c8_pkg::ITEM_LOAD, 4'h0, 1'b0, 8'h00, 12'h204, 8'hD0, 5'd0,  1'b0},
    '{c8_pkg::ITEM_LOAD, 4'h0, 1'b0, 8'h00, 12'h205, 8'hF2, 5'd0,  1'b0},
    '{c8_pkg::ITEM_EXEC, 4'h0, 1'b0, 8'h00, 12'h000, 8'h00, 5'd0,  1'b0},
    '{c8_pkg::ITEM_ROW,  4'h0, 1'b0, 8'h00, 12'h000, 8'h00, 5'd1,  1'b0},
    '{c8_pkg::ITEM_LOAD, 4'h0, 1'b0, 8'h00, 12'h206, 8'h12, 5'd0,  1'b0},
    '{c8_pkg::ITEM_LOAD, 4'h0, 1'b0, 8'h00, 12'h207, 8'h04, 5'd0,  1'b0},
    '{c8_pkg::ITEM_EXEC, 4'h0, 1'b0, 8'h00, 12'h000, 8'h00, 5'd0,  1'b0},
    '{c8_pkg::ITEM_EXEC, 4'h0, 1'b0, 8'h00, 12'h000, 8'h00, 5'd0,  1'b0},
    '{c8_pkg::ITEM_ROW,  4'h0, 1'b0, 8'h00, 12'h000, 8'h00, 5'd1,  1'b0},
    '{c8_pkg::ITEM_LOAD, 4'h0, 1'b0, 8'h00, 12'h206, 8'hF5, 5'd0,  1'b0},
    '{c8_pkg::ITEM_LOAD, 4'h0, 1'b0, 8'h00, 12'h207, 8'h0A, 5'd0,  1'b0},
    '{c8_pkg::ITEM_EXEC, 4'h0, 1'b0, 8'h00, 12'h000, 8'h00, 5'd0,  1'b0},
    '{c8_pkg::ITEM_EXEC, 4'h0, 1'b0, 8'h00, 12'h000, 8'h00, 5'd0,  1'b0},
    '{c8_pkg::ITEM_KEY,  4'hF, 1'b1, 8'h00, 12'h000, 8'h00, 5'd0,  1'b0},
    '{c8_pkg::ITEM_KEY,  4'hF, 1'b0, 8'h00, 12'h000, 8'h00, 5'd0,  1'b0},
    '{ITEM_UNUSED,       4'h0, 1'b0, 8'h00, 12'h000, 8'h00, 5'd0,  1'b0},
    '{c8_pkg::ITEM_LOAD, 4'h0, 1'b0, 8'h00, 12'hFFF, 8'hFF, 5'd0,  1'b0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [c8_pkg::IN_W-1:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [c8_pkg::OUT_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic cfg_data = 1'b0;

  always #2 clk = ~clk;

  chip8_cpu_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // machine state mirror
  logic [7:0]  mem [c8_pkg::MEM_BYTES];
  logic [7:0]  vr [16];
  logic [15:0] idx;
  logic [11:0] pc;
  logic [11:0] stk [16];
  logic [3:0]  sp;
  logic [7:0]  dt, st;
  logic [63:0] fb [c8_pkg::FB_ROWS];
  logic [15:0] keys;
  logic [4:0]  wt;
  logic q_shift, q_jump, q_keep;

  status_t expected_status [$];
  int mismatches = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;

  task automatic clear_machine();
    for (int a = 0; a < c8_pkg::MEM_BYTES; a++) mem[a] = 8'h00;
    for (int k = 0; k < c8_pkg::FONT_BYTES; k++) mem[c8_pkg::FONT_BASE + k] = c8_pkg::GLYPHS[k];
    for (int r = 0; r < 16; r++) begin
      vr[r] = 8'h00;
      stk[r] = 12'h000;
    end
    for (int r = 0; r < c8_pkg::FB_ROWS; r++) fb[r] = 64'd0;
    idx = 16'd0; pc = c8_pkg::PROGRAM_START; sp = 4'd0; dt = 8'd0; st = 8'd0;
    keys = 16'd0; wt = NO_WAIT;
    q_shift = 1'b0; q_jump = 1'b0; q_keep = 1'b0;
  endtask

  task automatic run_instruction(input logic [7:0] rnd, output logic changed);
    logic [7:0] hi, lo, t8, bits;
    logic [3:0] opn, x, y, n;
    logic [11:0] nnn, a;
    logic [8:0] t9;
    logic hit;
    int px, py, rr, cc;
    hi = mem[pc]; lo = mem[pc + 12'd1];
    opn = hi[7:4]; x = hi[3:0]; y = lo[7:4]; n = lo[3:0];
    nnn = {x, lo};
    changed = 1'b0;
    pc = pc + 12'd2;
    case (opn)
      c8_pkg::OPC_SYS: begin
        if (nnn == c8_pkg::NNN_CLS) begin
          for (int r = 0; r < c8_pkg::FB_ROWS; r++) fb[r] = 64'd0;
          changed = 1'b1;
        end else if (nnn == c8_pkg::NNN_RET) begin
          sp = sp - 4'd1;
          pc = stk[sp];
          stk[sp] = 12'h000;
        end
      end
      c8_pkg::OPC_JP: pc = nnn;
      c8_pkg::OPC_CALL: begin
        stk[sp] = pc;
        sp = sp + 4'd1;
        pc = nnn;
      end
      c8_pkg::OPC_SEB:  if (vr[x] == lo) pc = pc + 12'd2;
      c8_pkg::OPC_SNEB: if (vr[x] != lo) pc = pc + 12'd2;
      c8_pkg::OPC_SER:  if (vr[x] == vr[y]) pc = pc + 12'd2;
      c8_pkg::OPC_LDB:  vr[x] = lo;
      c8_pkg::OPC_ADDB: vr[x] = vr[x] + lo;
      c8_pkg::OPC_ALU: begin
        case (n)
          c8_pkg::ALU_MOV: vr[x] = vr[y];
          c8_pkg::ALU_OR:  vr[x] = vr[x] | vr[y];
          c8_pkg::ALU_AND: vr[x] = vr[x] & vr[y];
          c8_pkg::ALU_XOR: vr[x] = vr[x] ^ vr[y];
          c8_pkg::ALU_ADD: begin
            t9 = {1'b0, vr[x]} + {1'b0, vr[y]};
            vr[x] = t9[7:0];
            vr[15] = {7'd0, t9[8]};
          end
          c8_pkg::ALU_SUB: begin
            hit = vr[x] >= vr[y];
            vr[x] = vr[x] - vr[y];
            vr[15] = {7'd0, hit};
          end
          c8_pkg::ALU_SUBN: begin
            hit = vr[y] >= vr[x];
            vr[x] = vr[y] - vr[x];
            vr[15] = {7'd0, hit};
          end
          c8_pkg::ALU_SHR: begin
            t8 = q_shift ? vr[x] : vr[y];
            vr[x] = t8 >> 1;
            vr[15] = {7'd0, t8[0]};
          end
          c8_pkg::ALU_SHL: begin
            t8 = q_shift ? vr[x] : vr[y];
            vr[x] = t8 << 1;
            vr[15] = {7'd0, t8[7]};
          end
          default: ;
        endcase
      end
      c8_pkg::OPC_SNER: if (vr[x] != vr[y]) pc = pc + 12'd2;
      c8_pkg::OPC_LDI:  idx = {4'd0, nnn};
      c8_pkg::OPC_JPV:  pc = nnn + {4'd0, (q_jump ? vr[x] : vr[0])};
      c8_pkg::OPC_RND:  vr[x] = rnd & lo;
      c8_pkg::OPC_DRW: begin
        px = vr[x]; py = vr[y];
        vr[15] = 8'd0;
        hit = 1'b0;
        for (int r = 0; r < n; r++) begin
          a = idx[11:0] + 12'(r);
          bits = mem[a];
          rr = (py + r) % c8_pkg::FB_ROWS;
          for (int c = 0; c < 8; c++) begin
            if (bits[7-c]) begin
              cc = (px + c) % c8_pkg::FB_COLS;
              if (fb[rr][63-cc]) hit = 1'b1;
              fb[rr][63-cc] = ~fb[rr][63-cc];
            end
          end
        end
        vr[15] = {7'd0, hit};
        changed = 1'b1;
      end
      c8_pkg::OPC_KEY: begin
        if (lo == c8_pkg::KEY_SKP && keys[vr[x][3:0]]) pc = pc + 12'd2;
        else if (lo == c8_pkg::KEY_SKNP && !keys[vr[x][3:0]]) pc = pc + 12'd2;
      end
      default: begin
        case (lo)
          c8_pkg::FX_GET_DT: vr[x] = dt;
          c8_pkg::FX_WAIT: begin
            wt = {1'b0, x};
            pc = pc - 12'd2;
          end
          c8_pkg::FX_SET_DT: dt = vr[x];
          c8_pkg::FX_SET_ST: st = vr[x];
          c8_pkg::FX_ADD_I:  idx = idx + {8'd0, vr[x]};
          c8_pkg::FX_FONT:   idx = {4'd0, c8_pkg::FONT_BASE} + 16'(5 * int'(vr[x]));
          c8_pkg::FX_BCD: begin
            a = idx[11:0];
            mem[a] = vr[x] / 100;
            mem[a + 12'd1] = (vr[x] / 10) % 10;
            mem[a + 12'd2] = vr[x] % 10;
          end
          c8_pkg::FX_STORE: begin
            for (int i = 0; i <= x; i++) mem[idx[11:0] + 12'(i)] = vr[i];
            if (!q_keep) idx = idx + 16'(x) + 16'd1;
          end
          c8_pkg::FX_LOAD: begin
            for (int i = 0; i <= x; i++) vr[i] = mem[idx[11:0] + 12'(i)];
            if (!q_keep) idx = idx + 16'(x) + 16'd1;
          end
          default: ;
        endcase
      end
    endcase
  endtask

  task automatic predict_status(input item_t it, output status_t res);
    logic changed;
    changed = 1'b0;
    res = '0;
    case (it.op)
      c8_pkg::ITEM_EXEC: if (wt >= NO_WAIT) run_instruction(it.rnd, changed);
      c8_pkg::ITEM_TICK: begin
        if (dt != 0) dt = dt - 8'd1;
        if (st != 0) st = st - 8'd1;
      end
      c8_pkg::ITEM_KEY: begin
        keys[it.key] = it.down;
        if (it.down && wt < NO_WAIT) begin
          vr[wt[3:0]] = {4'd0, it.key};
          wt = NO_WAIT;
          pc = pc + 12'd2;
        end
      end
      c8_pkg::ITEM_LOAD: mem[it.addr] = it.data;
      c8_pkg::ITEM_ROW:  res.pixels = fb[it.row];
      default: ;
    endcase
    res.pc = pc;
    res.vf = vr[15];
    res.snd = st != 0;
    res.waiting = wt < NO_WAIT;
    res.changed = changed;
  endtask

  task automatic send_item(input item_t it);
    status_t res;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = it.op;
    in_tdata = {2'b00, it.row, it.data, it.addr, it.rnd, it.down, it.key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_status(it, res);
    if (it.typed) res = '{pc: c8_pkg::PROGRAM_START, default: '0};
    expected_status.push_back(res);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_quirk(input logic [1:0] index, input logic value);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      c8_pkg::CFG_SHIFT_IN_PLACE: q_shift = value;
      c8_pkg::CFG_JUMP_ADDS_VX:   q_jump = value;
      default:                    q_keep = value;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_quirks(input logic s, input logic j, input logic k);
    while (expected_status.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_quirk(c8_pkg::CFG_SHIFT_IN_PLACE, s);
    write_quirk(c8_pkg::CFG_JUMP_ADDS_VX, j);
    write_quirk(c8_pkg::CFG_KEEP_INDEX, k);
  endtask

  function automatic item_t random_item(input logic [2:0] op);
    item_t it;
    it = '0;
    it.op = op;
    it.key = 4'($urandom);
    it.down = 1'($urandom);
    it.rnd = 8'($urandom);
    it.addr = 12'($urandom);
    it.data = 8'($urandom);
    it.row = 5'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] random_instruction();
    logic [15:0] w;
    logic [7:0] fx [9];
    fx = '{c8_pkg::FX_GET_DT, c8_pkg::FX_WAIT, c8_pkg::FX_SET_DT, c8_pkg::FX_SET_ST,
           c8_pkg::FX_ADD_I, c8_pkg::FX_FONT, c8_pkg::FX_BCD, c8_pkg::FX_STORE,
           c8_pkg::FX_LOAD};
    w = 16'($urandom);
    case (w[15:12])
      c8_pkg::OPC_SYS: begin
        case ($urandom_range(3))
          0: w[11:0] = c8_pkg::NNN_CLS;
          1, 2: w[11:0] = c8_pkg::NNN_RET;
          default: ;
        endcase
      end
      c8_pkg::OPC_ALU:
        if ($urandom_range(9) != 0) w[3:0] = ($urandom_range(8) == 8) ? c8_pkg::ALU_SHL
                                             : 4'($urandom_range(7));
      c8_pkg::OPC_KEY:
        if ($urandom_range(9) != 0)
          w[7:0] = $urandom_range(1) ? c8_pkg::KEY_SKP : c8_pkg::KEY_SKNP;
      c8_pkg::OPC_MISC: begin
        if ($urandom_range(9) != 0) begin
          w[7:0] = fx[$urandom_range(8)];
          if (w[7:0] == c8_pkg::FX_WAIT && $urandom_range(2) != 0) w[7:0] = c8_pkg::FX_SET_ST;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic run_phase(input int count);
    item_t it;
    logic [15:0] w;
    int sent, pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (wt < NO_WAIT && pick < 40) begin
        it = random_item(c8_pkg::ITEM_KEY);
        it.down = 1'b1;
        send_item(it);
        sent++;
      end else if (pick < 62) begin
        w = random_instruction();
        it = random_item(c8_pkg::ITEM_LOAD);
        it.addr = pc; it.data = w[15:8];
        send_item(it);
        it = random_item(c8_pkg::ITEM_LOAD);
        it.addr = pc + 12'd1; it.data = w[7:0];
        send_item(it);
        send_item(random_item(c8_pkg::ITEM_EXEC));
        sent += 3;
      end else begin
        if (pick < 72) it = random_item(c8_pkg::ITEM_TICK);
        else if (pick < 80) it = random_item(c8_pkg::ITEM_KEY);
        else if (pick < 86) it = random_item(c8_pkg::ITEM_LOAD);
        else if (pick < 94) it = random_item(c8_pkg::ITEM_ROW);
        else if (pick < 97) it = random_item(c8_pkg::ITEM_EXEC);
        else it = random_item(3'($urandom_range(5, 7)));
        send_item(it);
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    status_t got, want;
    got = out_tdata[86:0];
    if (out_tvalid && out_tready) begin
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %h", got);
      end else begin
        want = expected_status.pop_front();
        if (got.pc !== want.pc || got.vf !== want.vf || got.snd !== want.snd ||
            got.waiting !== want.waiting || got.changed !== want.changed ||
            got.pixels !== want.pixels) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pc %h/%h vf %h/%h snd %b/%b wait %b/%b chg %b/%b pix %h/%h",
                     want.pc, got.pc, want.vf, got.vf, want.snd, got.snd,
                     want.waiting, got.waiting, want.changed, got.changed,
                     want.pixels, got.pixels);
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    clear_machine();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    set_quirks(1'b0, 1'b0, 1'b0);
    for (int i = 0; i < N_DIRECTED; i++) send_item(DIRECTED[i]);
    run_phase(270);
    set_quirks(1'b1, 1'b1, 1'b1);
    send_idle = 49;
    run_phase(280);
    set_quirks(1'b1, 1'b0, 1'b1);
    send_idle = 0;
    recv_stall = 49;
    run_phase(280);
    set_quirks(1'b0, 1'b1, 1'b0);
    send_idle = 37;
    recv_stall = 37;
    run_phase(280);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/c8_pkg.sv
hw/rtl/c8_mem.sv
hw/rtl/c8_regs.sv
hw/rtl/c8_fb.sv
hw/rtl/chip8_cpu_core.sv
test/tb_chip8_cpu_core.sv
